FILE: sv/baro_pressure_temp_compensation_defines.svh
// Assertion macros shared by the barometric compensation RTL.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is high.
`define BPTC_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("implication check failed");

// Implication after a fixed number of cycles, disabled while reset is high.
`define BPTC_ASSERT_DELAY(lbl, clk_s, rst_s, dly, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> ##dly (cons)) \
    else $error("delayed implication check failed");

`else

`define BPTC_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons)
`define BPTC_ASSERT_DELAY(lbl, clk_s, rst_s, dly, ante, cons)

`endif

`endif

FILE: sv/bptc_pkg.sv
// Types, widths and constants shared by the barometric compensation pipeline.
`default_nettype none

package bptc_pkg;

  // Field widths of the channels.
  localparam int RAW_W      = 24;
  localparam int ADC_BITS   = 24;
  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int PRESS_W    = 32;
  localparam int TEMP_W     = 20;

  // Pipeline depth: three stages in the first-order part, the rest after it.
  localparam int PIPE_DEPTH  = 10;
  localparam int FIRST_DEPTH = 3;
  localparam int TAIL_DEPTH  = PIPE_DEPTH - FIRST_DEPTH;

  // Temperature thresholds in 0.01 C.
  localparam int T_REF  = 2000;
  localparam int T_VLOW = -1500;

  // Shift amounts of the compensation formulas.
  localparam int REF_SH       = 8;
  localparam int TEMP_DIV_SH  = 23;
  localparam int OFF_BASE_SH  = 16;
  localparam int OFF_DIV_SH   = 7;
  localparam int SENS_BASE_SH = 15;
  localparam int SENS_DIV_SH  = 8;
  localparam int T2_SH        = 31;
  localparam int SENS_Q_SH    = 21;
  localparam int P_SH         = 15;

  // Internal widths, sized to the value ranges.
  localparam int DT_W    = RAW_W + 1;
  localparam int PROD1_W = DT_W + COEF_W + 1;
  localparam int Q_W     = 18;
  localparam int TEMP1_W = 19;
  localparam int OFF1_W  = 36;
  localparam int SENS1_W = 36;
  localparam int T2_W    = 17;
  localparam int SQ_W    = 35;
  localparam int SQ5_W   = 37;
  localparam int CORR_W  = 38;
  localparam int FIN_W   = 40;
  localparam int SQ21_W  = 20;
  localparam int PROD2_W = RAW_W + 1 + SQ21_W;
  localparam int DIFF_W  = PROD2_W + 1;

  localparam logic [RAW_W-1:0] ADC_MASK = RAW_W'((64'd1 << ADC_BITS) - 64'd1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESS_SENS = 3'd0,
    REG_PRESS_OFF  = 3'd1,
    REG_SENS_TCO   = 3'd2,
    REG_OFF_TCO    = 3'd3,
    REG_REF_TEMP   = 3'd4,
    REG_TEMP_SLOPE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [COEF_W-1:0] coef_pressure_sensitivity;
    logic [COEF_W-1:0] coef_pressure_offset;
    logic [COEF_W-1:0] coef_sensitivity_tempco;
    logic [COEF_W-1:0] coef_offset_tempco;
    logic [COEF_W-1:0] coef_reference_temp;
    logic [COEF_W-1:0] coef_temp_slope;
  } coef_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_press;
    logic [RAW_W-1:0] raw_temp;
  } sample_t;

  typedef struct packed {
    logic signed [PRESS_W-1:0] pressure_centimbar;
    logic signed [TEMP_W-1:0]  temp_centidegree;
  } result_t;

  // Beat leaving the first-order section.
  typedef struct packed {
    logic                      valid;
    logic [RAW_W-1:0]          d1;
    logic signed [Q_W-1:0]     q;
    logic signed [TEMP1_W-1:0] temp1;
    logic signed [TEMP1_W-1:0] e;
    logic                      lo;
    logic                      vlo;
    logic signed [OFF1_W-1:0]  off1;
    logic signed [SENS1_W-1:0] sens1;
    logic [T2_W-1:0]           t2;
  } first_t;

  // Beat leaving the second-order section.
  typedef struct packed {
    logic                     valid;
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp_f;
    logic signed [FIN_W-1:0]  off_f;
    logic signed [FIN_W-1:0]  sens_f;
  } second_t;

endpackage

`default_nettype wire

FILE: sv/bptc_cfg.sv
// Calibration coefficient registers with a plain write port.
`default_nettype none

module bptc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             we,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]   idx,
  input  logic [bptc_pkg::COEF_W-1:0]      data,
  output bptc_pkg::coef_t                  coefs
);
  import bptc_pkg::*;

  // Writes to indexes past the last coefficient are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= '0;
    end else if (we) begin
      unique case (idx)
        REG_PRESS_SENS: coefs.coef_pressure_sensitivity <= data;
        REG_PRESS_OFF:  coefs.coef_pressure_offset      <= data;
        REG_SENS_TCO:   coefs.coef_sensitivity_tempco   <= data;
        REG_OFF_TCO:    coefs.coef_offset_tempco        <= data;
        REG_REF_TEMP:   coefs.coef_reference_temp       <= data;
        REG_TEMP_SLOPE: coefs.coef_temp_slope           <= data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/bptc_first.sv
// First-order section: dT, coefficient products, TEMP, OFF and SENS (three stages).
`default_nettype none

module bptc_first (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  bptc_pkg::sample_t sample,
  input  bptc_pkg::coef_t   coefs,
  output bptc_pkg::first_t  stage_out
);
  import bptc_pkg::*;

  localparam logic signed [PROD1_W-1:0] TEMP_BIAS =
    PROD1_W'((64'd1 << TEMP_DIV_SH) - 64'd1);
  localparam logic signed [PROD1_W-1:0] OFF_BIAS =
    PROD1_W'((64'd1 << OFF_DIV_SH) - 64'd1);
  localparam logic signed [PROD1_W-1:0] SENS_BIAS =
    PROD1_W'((64'd1 << SENS_DIV_SH) - 64'd1);

  // Stage 1: mask the readings and form dT.
  logic [RAW_W-1:0]       d1_in;
  logic [RAW_W-1:0]       d2_in;
  logic signed [DT_W-1:0] dt_in;
  logic                   v1;
  logic [RAW_W-1:0]       d1_s1;
  logic signed [DT_W-1:0] dt_s1;

  assign d1_in = sample.raw_press & ADC_MASK;
  assign d2_in = sample.raw_temp & ADC_MASK;
  assign dt_in = $signed({1'b0, d2_in})
               - $signed(DT_W'({coefs.coef_reference_temp, {REF_SH{1'b0}}}));

  always_ff @(posedge clk) begin
    d1_s1 <= d1_in;
    dt_s1 <= dt_in;
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  // Stage 2: the four products of dT.
  logic signed [COEF_W:0]      c6_s;
  logic signed [COEF_W:0]      c4_s;
  logic signed [COEF_W:0]      c3_s;
  logic signed [PROD1_W-1:0]   pt_c;
  logic signed [PROD1_W-1:0]   po_c;
  logic signed [PROD1_W-1:0]   ps_c;
  logic signed [2*DT_W-1:0]    dd_c;
  logic                        v2;
  logic [RAW_W-1:0]            d1_s2;
  logic signed [PROD1_W-1:0]   pt;
  logic signed [PROD1_W-1:0]   po;
  logic signed [PROD1_W-1:0]   ps;
  logic [T2_W-1:0]             t2_s2;

  assign c6_s = $signed({1'b0, coefs.coef_temp_slope});
  assign c4_s = $signed({1'b0, coefs.coef_offset_tempco});
  assign c3_s = $signed({1'b0, coefs.coef_sensitivity_tempco});
  assign pt_c = dt_s1 * c6_s;
  assign po_c = dt_s1 * c4_s;
  assign ps_c = dt_s1 * c3_s;
  assign dd_c = dt_s1 * dt_s1;

  always_ff @(posedge clk) begin
    d1_s2 <= d1_s1;
    pt    <= pt_c;
    po    <= po_c;
    ps    <= ps_c;
    // dT squared is never negative, so the division is a plain shift.
    t2_s2 <= dd_c[T2_SH +: T2_W];
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  // Stage 3: divisions that truncate toward zero, then the first-order sums.
  logic signed [PROD1_W-1:0] pt_adj;
  logic signed [PROD1_W-1:0] po_adj;
  logic signed [PROD1_W-1:0] ps_adj;
  logic signed [PROD1_W-1:0] q_full;
  logic signed [PROD1_W-1:0] off_q;
  logic signed [PROD1_W-1:0] sens_q;
  logic signed [Q_W-1:0]     q_c;
  first_t                    first_next;

  assign pt_adj = pt + (pt[PROD1_W-1] ? TEMP_BIAS : '0);
  assign po_adj = po + (po[PROD1_W-1] ? OFF_BIAS : '0);
  assign ps_adj = ps + (ps[PROD1_W-1] ? SENS_BIAS : '0);
  assign q_full = pt_adj >>> TEMP_DIV_SH;
  assign off_q  = po_adj >>> OFF_DIV_SH;
  assign sens_q = ps_adj >>> SENS_DIV_SH;
  assign q_c    = q_full[Q_W-1:0];

  always_comb begin
    first_next.valid = v2;
    first_next.d1    = d1_s2;
    first_next.q     = q_c;
    first_next.temp1 = TEMP1_W'(q_c) + TEMP1_W'(T_REF);
    // TEMP + 1500, formed straight from the quotient.
    first_next.e     = TEMP1_W'(q_c) + TEMP1_W'(T_REF - T_VLOW);
    // TEMP is below 20.00 C exactly when the quotient is negative.
    first_next.lo    = q_c[Q_W-1];
    first_next.vlo   = q_c < Q_W'(T_VLOW - T_REF);
    first_next.off1  = OFF1_W'(off_q)
                     + $signed(OFF1_W'({coefs.coef_pressure_offset, {OFF_BASE_SH{1'b0}}}));
    first_next.sens1 = SENS1_W'(sens_q)
                     + $signed(SENS1_W'({coefs.coef_pressure_sensitivity,
                                         {SENS_BASE_SH{1'b0}}}));
    first_next.t2    = t2_s2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out <= '0;
    end else begin
      stage_out <= first_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bptc_second.sv
// Second-order section: squares, low-temperature corrections and their subtraction.
`default_nettype none

module bptc_second (
  input  logic              clk,
  input  logic              rst,
  input  bptc_pkg::first_t  stage_in,
  output bptc_pkg::second_t stage_out
);
  import bptc_pkg::*;

  // Stage 4: squares of the temperature offsets, and the corrected temperature.
  logic signed [2*Q_W-1:0]     dsq_c;
  logic signed [2*TEMP1_W-1:0] esq_c;
  logic signed [TEMP_W-1:0]    t2_corr;
  logic                        v4;
  logic [RAW_W-1:0]            d1_s4;
  logic [SQ_W-1:0]             dsq;
  logic [SQ_W-1:0]             esq;
  logic                        lo_s4;
  logic                        vlo_s4;
  logic signed [OFF1_W-1:0]    off1_s4;
  logic signed [SENS1_W-1:0]   sens1_s4;
  logic signed [TEMP_W-1:0]    tempf_s4;

  assign dsq_c   = stage_in.q * stage_in.q;
  assign esq_c   = stage_in.e * stage_in.e;
  assign t2_corr = stage_in.lo ? $signed(TEMP_W'(stage_in.t2)) : '0;

  always_ff @(posedge clk) begin
    d1_s4    <= stage_in.d1;
    dsq      <= dsq_c[SQ_W-1:0];
    esq      <= esq_c[SQ_W-1:0];
    lo_s4    <= stage_in.lo;
    vlo_s4   <= stage_in.vlo;
    off1_s4  <= stage_in.off1;
    sens1_s4 <= stage_in.sens1;
    tempf_s4 <= TEMP_W'(stage_in.temp1) - t2_corr;
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= stage_in.valid;
    end
  end

  // Stage 5: OFF2 and SENS2 from shift-and-add multiples of the squares.
  logic [SQ5_W-1:0]          sq5;
  logic [SQ5_W-1:0]          esq7;
  logic [CORR_W-1:0]         esq11;
  logic [CORR_W-1:0]         off2_c;
  logic [CORR_W-1:0]         sens2_c;
  logic                      v5;
  logic [RAW_W-1:0]          d1_s5;
  logic [CORR_W-1:0]         off2;
  logic [CORR_W-1:0]         sens2;
  logic signed [OFF1_W-1:0]  off1_s5;
  logic signed [SENS1_W-1:0] sens1_s5;
  logic signed [TEMP_W-1:0]  tempf_s5;

  assign sq5   = (SQ5_W'(dsq) << 2) + SQ5_W'(dsq);
  assign esq7  = (SQ5_W'(esq) << 3) - SQ5_W'(esq);
  assign esq11 = (CORR_W'(esq) << 3) + (CORR_W'(esq) << 1) + CORR_W'(esq);

  // All terms are non-negative, so the halving and quartering are shifts.
  always_comb begin
    off2_c  = '0;
    sens2_c = '0;
    if (lo_s4) begin
      off2_c  = CORR_W'(sq5 >> 1) + (vlo_s4 ? CORR_W'(esq7) : '0);
      sens2_c = CORR_W'(sq5 >> 2) + (vlo_s4 ? (esq11 >> 1) : '0);
    end
  end

  always_ff @(posedge clk) begin
    d1_s5    <= d1_s4;
    off2     <= off2_c;
    sens2    <= sens2_c;
    off1_s5  <= off1_s4;
    sens1_s5 <= sens1_s4;
    tempf_s5 <= tempf_s4;
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  // Stage 6: apply the corrections.
  second_t second_next;

  always_comb begin
    second_next.valid  = v5;
    second_next.d1     = d1_s5;
    second_next.temp_f = tempf_s5;
    second_next.off_f  = FIN_W'(off1_s5) - $signed(FIN_W'(off2));
    second_next.sens_f = FIN_W'(sens1_s5) - $signed(FIN_W'(sens2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out <= '0;
    end else begin
      stage_out <= second_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bptc_press.sv
// Pressure section: SENS scaling, D1 product, offset, final scaling and saturation.
`default_nettype none

module bptc_press (
  input  logic              clk,
  input  logic              rst,
  input  bptc_pkg::second_t stage_in,
  output logic              done,
  output bptc_pkg::result_t result
);
  import bptc_pkg::*;

  localparam logic signed [FIN_W-1:0] SENS_Q_BIAS =
    FIN_W'((64'd1 << SENS_Q_SH) - 64'd1);
  localparam logic signed [DIFF_W-1:0] P_BIAS =
    DIFF_W'((64'd1 << P_SH) - 64'd1);
  localparam logic signed [DIFF_W-1:0] P_MAX =
    {{(DIFF_W-PRESS_W+1){1'b0}}, {(PRESS_W-1){1'b1}}};
  localparam logic signed [DIFF_W-1:0] P_MIN =
    {{(DIFF_W-PRESS_W+1){1'b1}}, {(PRESS_W-1){1'b0}}};

  // Stage 7: SENS / 2^21, truncated toward zero.
  logic signed [FIN_W-1:0]  sens_adj;
  logic signed [FIN_W-1:0]  sens_div;
  logic                     v7;
  logic [RAW_W-1:0]         d1_s7;
  logic signed [SQ21_W-1:0] sq21;
  logic signed [FIN_W-1:0]  off_s7;
  logic signed [TEMP_W-1:0] temp_s7;

  assign sens_adj = stage_in.sens_f + (stage_in.sens_f[FIN_W-1] ? SENS_Q_BIAS : '0);
  assign sens_div = sens_adj >>> SENS_Q_SH;

  always_ff @(posedge clk) begin
    d1_s7   <= stage_in.d1;
    sq21    <= sens_div[SQ21_W-1:0];
    off_s7  <= stage_in.off_f;
    temp_s7 <= stage_in.temp_f;
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= stage_in.valid;
    end
  end

  // Stage 8: D1 times the scaled sensitivity.
  logic signed [PROD2_W-1:0] prod_c;
  logic                      v8;
  logic signed [PROD2_W-1:0] prod;
  logic signed [FIN_W-1:0]   off_s8;
  logic signed [TEMP_W-1:0]  temp_s8;

  assign prod_c = $signed({1'b0, d1_s7}) * sq21;

  always_ff @(posedge clk) begin
    prod    <= prod_c;
    off_s8  <= off_s7;
    temp_s8 <= temp_s7;
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
  end

  // Stage 9: subtract the offset.
  logic                     v9;
  logic signed [DIFF_W-1:0] diff;
  logic signed [TEMP_W-1:0] temp_s9;

  always_ff @(posedge clk) begin
    diff    <= DIFF_W'(prod) - DIFF_W'(off_s8);
    temp_s9 <= temp_s8;
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
  end

  // Stage 10: divide by 2^15 toward zero and saturate to 32 bits.
  logic signed [DIFF_W-1:0]  diff_adj;
  logic signed [DIFF_W-1:0]  p_div;
  logic signed [PRESS_W-1:0] p_sat;

  assign diff_adj = diff + (diff[DIFF_W-1] ? P_BIAS : '0);
  assign p_div    = diff_adj >>> P_SH;

  always_comb begin
    priority if (p_div > P_MAX) begin
      p_sat = P_MAX[PRESS_W-1:0];
    end else if (p_div < P_MIN) begin
      p_sat = P_MIN[PRESS_W-1:0];
    end else begin
      p_sat = p_div[PRESS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    result.pressure_centimbar <= p_sat;
    result.temp_centidegree   <= temp_s9;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v9;
    end
  end

endmodule

`default_nettype wire

FILE: sv/baro_pressure_temp_compensation.sv
// Top level of the second-order barometric pressure and temperature compensation.
//
// Usage:
//   Coefficients C1..C6 are loaded through cfg_we / cfg_idx / cfg_data, one
//   register per cycle, indexes 0 to 5; other indexes are ignored. Load them
//   while no reading is in flight.
//   A reading pair (D1 pressure, D2 temperature) is taken on every rising edge
//   where start is high and busy is low. busy is always low: the pipeline takes
//   one beat per cycle, back to back.
//   Each result appears on result for one cycle with done high, once its
//   reading has passed the register stages of the pipeline: three for the
//   first-order terms, three for the squares and corrections, four for the
//   pressure product, offset and scaling.
//   Throughput is one reading per cycle; results leave in reading order.
//   The receiver cannot stall; done is a pure strobe and must be captured.
//   Synchronous reset clears all coefficients to zero and drops every beat in
//   flight; no done strobe follows for readings taken before reset.
`default_nettype none

`include "baro_pressure_temp_compensation_defines.svh"

module baro_pressure_temp_compensation (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  bptc_pkg::sample_t               sample,
  output logic                            done,
  output bptc_pkg::result_t               result,
  input  logic                            cfg_we,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bptc_pkg::COEF_W-1:0]     cfg_data
);
  import bptc_pkg::*;

  coef_t   coefs;
  first_t  first_out;
  second_t second_out;
  logic    accept;
  logic    warm_beat;
  logic    cold_beat;
  logic    warm_result;

  // Every stage advances each cycle, so the input side never waits.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  bptc_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .idx   (cfg_idx),
    .data  (cfg_data),
    .coefs (coefs)
  );

  bptc_first u_first (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .sample    (sample),
    .coefs     (coefs),
    .stage_out (first_out)
  );

  bptc_second u_second (
    .clk       (clk),
    .rst       (rst),
    .stage_in  (first_out),
    .stage_out (second_out)
  );

  bptc_press u_press (
    .clk      (clk),
    .rst      (rst),
    .stage_in (second_out),
    .done     (done),
    .result   (result)
  );

  // Temperature region of the beat leaving the first-order section, and of the result.
  assign warm_beat   = first_out.valid && !first_out.lo;
  assign cold_beat   = first_out.valid && first_out.lo;
  assign warm_result = result.temp_centidegree >= TEMP_W'(T_REF);

  // Every accepted beat comes out after the full pipeline depth.
  `BPTC_ASSERT_DELAY(a_latency, clk, rst, PIPE_DEPTH, accept, done)
  // No result without a beat taken the full pipeline depth earlier.
  `BPTC_ASSERT_IMPLY(a_no_phantom, clk, rst, done, $past(accept, PIPE_DEPTH))
  // A beat at or above 20.00 C gets no T2 and stays at or above it.
  `BPTC_ASSERT_DELAY(a_warm_temp, clk, rst, TAIL_DEPTH, warm_beat, done && warm_result)
  // A beat below 20.00 C never moves up, and so stays below it.
  `BPTC_ASSERT_DELAY(a_cold_temp, clk, rst, TAIL_DEPTH, cold_beat, done && !warm_result)

endmodule

`default_nettype wire
